[sv/tea_variant_block_decrypt_assert.svh]
// Assertion macros for the block decryptor.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef TEA_VARIANT_BLOCK_DECRYPT_ASSERT_SVH
`define TEA_VARIANT_BLOCK_DECRYPT_ASSERT_SVH

// clocked assertion, disabled during reset
`define TVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: when cond holds, prop must hold in the same cycle
`define TVD_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle form: when cond holds, prop must hold in the next cycle
`define TVD_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[sv/teavd_pkg.sv]
// Shared constants, register indexes and round-sum function for the decryptor.
// No dependencies.
`default_nettype none

package teavd_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned HALF_STEPS = 2 * ROUNDS;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  localparam logic [IDX_W-1:0] KEY0_IDX = 2'd0;
  localparam logic [IDX_W-1:0] KEY1_IDX = 2'd1;
  localparam logic [IDX_W-1:0] KEY2_IDX = 2'd2;
  localparam logic [IDX_W-1:0] KEY3_IDX = 2'd3;

  localparam logic [WORD_W-1:0] KEY0_RST = 32'h4C7ADF03;
  // key word 1 is held negated: its reset value is -0x5F30E75F
  localparam logic [WORD_W-1:0] KEY1_NEG_RST = 32'hA0CF18A1;
  localparam logic [WORD_W-1:0] KEY2_RST = 32'h1D149820;
  localparam logic [WORD_W-1:0] KEY3_RST = 32'h03985ADF;

  // running sum used in round r: DELTA * (ROUNDS - r), mod 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned r);
    logic [WORD_W-1:0] left;
    left = WORD_W'(ROUNDS - r);
    return WORD_W'(DELTA * left);
  endfunction

endpackage

`default_nettype wire

[sv/teavd_cell.sv]
// One half-round cell: updates the destination word from the source word.
// Uses teavd_pkg for widths.
`default_nettype none

module teavd_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]   sum_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]   key_l_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]   key_r_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]   x_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]   y_i,
  output logic                                valid_o,
  output logic      [teavd_pkg::WORD_W-1:0]   x_o,
  output logic      [teavd_pkg::WORD_W-1:0]   y_o
);

  logic                          valid_q;
  logic [teavd_pkg::WORD_W-1:0]  x_q, x_d;
  logic [teavd_pkg::WORD_W-1:0]  y_q, y_d;
  logic [teavd_pkg::WORD_W-1:0]  mix;

  always_comb begin
    mix = ((x_i << 4) - key_l_i) ^ (x_i + sum_i) ^ ((x_i >> 5) - key_r_i);
    x_d = x_i;
    y_d = y_i - mix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

`default_nettype wire

[sv/tea_variant_block_decrypt.sv]
// Top level: key registers and a chain of 64 half-round cells.
// Uses teavd_pkg, teavd_cell and tea_variant_block_decrypt_assert.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o    | cipher_word_a_i, cipher_word_b_i
//  out     | output    | out_valid_o / out_ready_i  | plain_word_a_o, plain_word_b_o
//  cfg     | input     | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; each half-round cell is a register stage.
// The last cell is the output register.
// A stalled output word freezes the whole chain; in_ready_o is high while the output is empty or out_ready_i is high.
// Reset clears the valid bits and loads the default key words.
`default_nettype none

module tea_variant_block_decrypt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [teavd_pkg::WORD_W-1:0]  cipher_word_a_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]  cipher_word_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [teavd_pkg::WORD_W-1:0]  plain_word_a_o,
  output logic      [teavd_pkg::WORD_W-1:0]  plain_word_b_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [teavd_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [teavd_pkg::WORD_W-1:0]  cfg_data_i
);

  `include "tea_variant_block_decrypt_assert.svh"

  localparam int unsigned N = teavd_pkg::HALF_STEPS;

  logic [teavd_pkg::WORD_W-1:0] key0_q, key1_neg_q, key2_q, key3_q;
  logic [teavd_pkg::WORD_W-1:0] a_s [N+1];
  logic [teavd_pkg::WORD_W-1:0] b_s [N+1];
  logic [N:0]                   v_s;
  logic                         en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= teavd_pkg::KEY0_RST;
      key1_neg_q <= teavd_pkg::KEY1_NEG_RST;
      key2_q     <= teavd_pkg::KEY2_RST;
      key3_q     <= teavd_pkg::KEY3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        teavd_pkg::KEY0_IDX: key0_q     <= cfg_data_i;
        teavd_pkg::KEY1_IDX: key1_neg_q <= (~cfg_data_i) + teavd_pkg::WORD_W'(1);
        teavd_pkg::KEY2_IDX: key2_q     <= cfg_data_i;
        teavd_pkg::KEY3_IDX: key3_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !v_s[N] || out_ready_i;
  assign in_ready_o = en;
  assign v_s[0]     = in_valid_i;
  assign a_s[0]     = cipher_word_a_i;
  assign b_s[0]     = cipher_word_b_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [teavd_pkg::WORD_W-1:0] Sum = teavd_pkg::round_sum(i / 2);
    if (i % 2 == 0) begin : g_b
      // b -= f(a)
      teavd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (v_s[i]),
        .sum_i   (Sum),
        .key_l_i (key2_q),
        .key_r_i (key3_q),
        .x_i     (a_s[i]),
        .y_i     (b_s[i]),
        .valid_o (v_s[i+1]),
        .x_o     (a_s[i+1]),
        .y_o     (b_s[i+1])
      );
    end else begin : g_a
      // a -= f(b), key word 1 added via its negation
      teavd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (v_s[i]),
        .sum_i   (Sum),
        .key_l_i (key0_q),
        .key_r_i (key1_neg_q),
        .x_i     (b_s[i]),
        .y_i     (a_s[i]),
        .valid_o (v_s[i+1]),
        .x_o     (b_s[i+1]),
        .y_o     (a_s[i+1])
      );
    end
  end

  assign out_valid_o    = v_s[N];
  assign plain_word_a_o = a_s[N];
  assign plain_word_b_o = b_s[N];

  `TVD_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "ready low with empty output")
  `TVD_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, v_s[1], "accepted word lost")
  `TVD_ASSERT_NXT(a_no_invent, !in_valid_i && in_ready_o, !v_s[1], "word appeared from nothing")
  `TVD_ASSERT_NXT(a_key1_neg, cfg_we_i && cfg_index_i == teavd_pkg::KEY1_IDX,
                  (key1_neg_q + $past(cfg_data_i)) == '0, "key word 1 negation wrong")

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for tea_variant_block_decrypt: streams cipher words through
// a queue-fed driver and checks every plaintext word against an in-bench decipher.
// Depends on teavd_pkg and the block RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_BLOCKS = 6;
  localparam int unsigned ITEMS_PER_BLOCK = 317;

  typedef struct packed {
    logic [teavd_pkg::WORD_W-1:0] a;
    logic [teavd_pkg::WORD_W-1:0] b;
  } word_pair_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [teavd_pkg::WORD_W-1:0] cipher_word_a_i = '0;
  logic [teavd_pkg::WORD_W-1:0] cipher_word_b_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [teavd_pkg::WORD_W-1:0] plain_word_a_o;
  logic [teavd_pkg::WORD_W-1:0] plain_word_b_o;
  logic                         cfg_we_i = 1'b0;
  logic [teavd_pkg::IDX_W-1:0]  cfg_index_i = teavd_pkg::KEY0_IDX;
  logic [teavd_pkg::WORD_W-1:0] cfg_data_i = '0;

  word_pair_t                   pending_blocks[$];
  word_pair_t                   expected_plain[$];
  logic [teavd_pkg::WORD_W-1:0] key_w [4];
  int unsigned                  tx_idle_pct = 0;
  int unsigned                  rx_idle_pct = 0;
  bit                           tx_hold = 1'b0;
  int unsigned                  mismatches = 0;
  int unsigned                  cycles = 0;

  tea_variant_block_decrypt u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cipher_word_a_i (cipher_word_a_i),
    .cipher_word_b_i (cipher_word_b_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .plain_word_a_o  (plain_word_a_o),
    .plain_word_b_o  (plain_word_b_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tea_variant_block_decrypt: mismatch");
      $finish;
    end
  end

  // 32 rounds; b is updated first, then a from the new b
  function automatic word_pair_t decipher(input word_pair_t c);
    logic [teavd_pkg::WORD_W-1:0] a, b, s;
    word_pair_t p;
    a = c.a;
    b = c.b;
    s = teavd_pkg::WORD_W'(teavd_pkg::DELTA * teavd_pkg::ROUNDS);
    for (int r = 0; r < teavd_pkg::ROUNDS; r++) begin
      b = b - (((a << 4) - key_w[2]) ^ (a + s) ^ ((a >> 5) - key_w[3]));
      a = a - (((b << 4) - key_w[0]) ^ (b + s) ^ ((b >> 5) + key_w[1]));
      s = s - teavd_pkg::DELTA;
    end
    p.a = a;
    p.b = b;
    return p;
  endfunction

  function automatic logic [teavd_pkg::WORD_W-1:0] rand_word();
    logic [teavd_pkg::WORD_W-1:0] one_hot;
    one_hot = teavd_pkg::WORD_W'(1) << $urandom_range(teavd_pkg::WORD_W - 1);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(input string what, input word_pair_t want, input word_pair_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected a=%08h b=%08h, got a=%08h b=%08h",
               $realtime, what, want.a, want.b, got.a, got.b);
  endtask

  // driver: holds valid and payload until the word is taken
  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    word_pair_t blk;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cipher_word_a_i <= '0;
      cipher_word_b_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_plain.push_back(decipher({cipher_word_a_i, cipher_word_b_i}));
      if (!in_valid_i || in_ready_o) begin
        if (pending_blocks.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
          blk = pending_blocks.pop_front();
          in_valid_i <= 1'b1;
          cipher_word_a_i <= blk.a;
          cipher_word_b_i <= blk.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, in-order compare
  always @(posedge clk_i or negedge rst_ni) begin : p_check
    word_pair_t want;
    word_pair_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.a = plain_word_a_o;
        got.b = plain_word_b_o;
        if (expected_plain.size() == 0) begin
          report("unexpected word", '0, got);
        end else begin
          want = expected_plain.pop_front();
          if (got.a !== want.a) report("plain_word_a", want, got);
          if (got.b !== want.b) report("plain_word_b", want, got);
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic drain();
    @(negedge clk_i);
    while (pending_blocks.size() != 0 || in_valid_i || expected_plain.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic load_keys(input logic [teavd_pkg::WORD_W-1:0] k0,
                           input logic [teavd_pkg::WORD_W-1:0] k1,
                           input logic [teavd_pkg::WORD_W-1:0] k2,
                           input logic [teavd_pkg::WORD_W-1:0] k3);
    logic [teavd_pkg::WORD_W-1:0] vals [4];
    logic [teavd_pkg::IDX_W-1:0]  idx [4];
    vals = '{k0, k1, k2, k3};
    idx = '{teavd_pkg::KEY0_IDX, teavd_pkg::KEY1_IDX, teavd_pkg::KEY2_IDX,
            teavd_pkg::KEY3_IDX};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      key_w[idx[i]] = vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_block(input logic [teavd_pkg::WORD_W-1:0] a,
                             input logic [teavd_pkg::WORD_W-1:0] b);
    word_pair_t blk;
    blk.a = a;
    blk.b = b;
    pending_blocks.push_back(blk);
  endtask

  initial begin
    key_w[0] = teavd_pkg::KEY0_RST;
    key_w[1] = -teavd_pkg::KEY1_NEG_RST;  // package holds key word 1 negated
    key_w[2] = teavd_pkg::KEY2_RST;
    key_w[3] = teavd_pkg::KEY3_RST;
    tx_idle_pct = 7;
    rx_idle_pct = 58;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words at reset keys
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'h0000_0000, 32'hFFFF_FFFF);
    queue_block(32'hFFFF_FFFF, 32'h0000_0000);
    queue_block(32'h8000_0000, 32'h0000_0001);
    queue_block(32'h0000_0001, 32'h8000_0000);
    queue_block(32'h7FFF_FFFF, 32'hFFFF_FFFE);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA);
    queue_block(32'h9E37_79B9, 32'h61C8_8647);
    queue_block(32'h0000_0010, 32'h0000_0020);
    queue_block(32'hDEAD_BEEF, 32'h0123_4567);
    drain();

    load_keys('0, '0, '0, '0);
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'h8000_0000, 32'h7FFF_FFFF);
    queue_block(32'h1234_5678, 32'h9ABC_DEF0);
    drain();

    load_keys('1, '1, '1, '1);
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'hFFFF_FFFF, 32'h0000_0000);
    queue_block(32'h0F0F_0F0F, 32'hF0F0_F0F0);
    drain();

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk / 2)
        0: begin tx_idle_pct = 7;  rx_idle_pct = 58; end
        1: begin tx_idle_pct = 58; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (blk == 1)
        load_keys(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
      else
        load_keys(rand_word(), rand_word(), rand_word(), rand_word());
      for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
        queue_block(rand_word(), rand_word());
        if (blk == 0 && i == ITEMS_PER_BLOCK / 2) begin
          // let the first half go out, then hold the sender until the pipe is empty
          while (pending_blocks.size() != 0) @(negedge clk_i);
          tx_hold = 1'b1;
          @(negedge clk_i);
          while (in_valid_i || expected_plain.size() != 0) @(negedge clk_i);
          tx_hold = 1'b0;
        end
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && expected_plain.size() == 0)
      $display("tea_variant_block_decrypt: match");
    else
      $display("tea_variant_block_decrypt: mismatch");
    $finish;
  end

endmodule

[tea_variant_block_decrypt.f]
+incdir+sv
sv/teavd_pkg.sv
sv/teavd_cell.sv
sv/tea_variant_block_decrypt.sv
bench/tb.sv
